// ----- hdl/h264dpk_pkg.sv -----
// shared types and constants for the h264 rtp depacketizer
// used by every module of the block, no dependencies

package h264dpk_pkg;

    localparam int unsigned MAX_FRAME_BYTES_DEF = 1024 * 2 * 1024;
    localparam int unsigned QUEUE_DEPTH_DEF     = 8;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned FRAME_LEN_W = 22;
    localparam int unsigned IN_USER_W   = 2;
    localparam int unsigned OUT_TDATA_W = 40;

    // s_tuser bit positions
    localparam int unsigned USER_FIRST_BIT  = 0;
    localparam int unsigned USER_MARKER_BIT = 1;

    // nal unit types
    localparam logic [4:0] NAL_SINGLE_MIN = 5'd1;
    localparam logic [4:0] NAL_SINGLE_MAX = 5'hc;
    localparam logic [4:0] NAL_STAP_A     = 5'd24;
    localparam logic [4:0] NAL_FU_A       = 5'd28;

    // fu header flags
    localparam int unsigned FU_START_BIT = 7;
    localparam int unsigned FU_END_BIT   = 6;

    // start code 00 00 00 01 then the nal header
    localparam logic [2:0]        START_ONE_IDX  = 3'd3;
    localparam logic [2:0]        START_LAST_IDX = 3'd4;
    localparam logic [BYTE_W-1:0] START_ONE_BYTE = 8'h01;

    typedef enum logic [2:0] {
        PH_HDR,     // awaiting packet header
        PH_SGL,     // single nal body
        PH_LHI,     // stap length high
        PH_LLO,     // stap length low
        PH_SHD,     // stap nal header
        PH_SBD,     // stap nal body
        PH_FUH,     // fu header
        PH_FUB      // fu body or discard
    } phase_t;

    typedef enum logic [1:0] {
        CMD_NONE,   // one beat without stream data
        CMD_BYTE,   // one stream byte
        CMD_START   // start code plus nal header, five beats
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t               kind;
        logic [BYTE_W-1:0]       data;
        logic                    done;
        logic [FRAME_LEN_W-1:0]  flen;
        logic                    drop;
        logic                    kreq;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- hdl/h264dpk_front.sv -----
// packet parser: classifies each payload byte and issues one command per beat
// depends on h264dpk_pkg

module h264dpk_front #(
    parameter int unsigned MAX_FRAME_BYTES = h264dpk_pkg::MAX_FRAME_BYTES_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [h264dpk_pkg::BYTE_W-1:0]       s_tdata,
    input  logic [h264dpk_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic                                 s_tlast,
    input  h264dpk_pkg::q_status_t               q_status,
    output logic                                 push,
    output h264dpk_pkg::cmd_t                    push_cmd
);

    localparam int unsigned FC_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int unsigned FL_W  = h264dpk_pkg::FRAME_LEN_W;
    localparam logic [FC_W-1:0] LIM_ONE  = FC_W'(MAX_FRAME_BYTES - 1);
    localparam logic [FC_W-1:0] LIM_FIVE = FC_W'(MAX_FRAME_BYTES - 5);
    localparam logic [FC_W-1:0] FC_FIVE  = FC_W'(5);

    h264dpk_pkg::phase_t phase_reg, phase_next;
    logic [2:0]          ind_reg, ind_next;
    logic [7:0]          lhi_reg, lhi_next;
    logic [15:0]         left_reg, left_next;
    logic                frag_open_reg, frag_open_next;
    logic                discard_reg, discard_next;
    logic                perr_reg, perr_next;
    logic [FC_W-1:0]     fc_reg, fc_next;
    logic                good_reg, good_next;

    logic                room_one;
    logic                room_five;
    logic                first;
    logic                marker;
    logic [FC_W+FL_W-1:0] fc_ext;

    assign s_tready  = !q_status.full;
    assign push      = s_tvalid && s_tready;
    assign first     = s_tuser[h264dpk_pkg::USER_FIRST_BIT];
    assign marker    = s_tuser[h264dpk_pkg::USER_MARKER_BIT];
    assign room_one  = fc_reg <= LIM_ONE;
    assign room_five = fc_reg <= LIM_FIVE;

    always_comb begin
        logic [4:0]  ntype;
        logic [15:0] len;
        logic        fu_s;
        logic        fu_e;

        phase_next     = phase_reg;
        ind_next       = ind_reg;
        lhi_next       = lhi_reg;
        left_next      = left_reg;
        frag_open_next = frag_open_reg;
        discard_next   = discard_reg;
        perr_next      = perr_reg;
        fc_next        = fc_reg;
        good_next      = good_reg;

        push_cmd      = '0;
        push_cmd.kind = h264dpk_pkg::CMD_NONE;
        push_cmd.data = s_tdata;

        ntype = s_tdata[4:0];
        len   = {lhi_reg, s_tdata};
        fu_s  = s_tdata[h264dpk_pkg::FU_START_BIT];
        fu_e  = s_tdata[h264dpk_pkg::FU_END_BIT];
        fc_ext = '0;

        if (first && phase_reg != h264dpk_pkg::PH_HDR) begin
            // packet end was missed, the new packet is bad as a whole
            perr_next  = 1'b1;
            phase_next = h264dpk_pkg::PH_FUB;
        end else begin
            unique case (phase_reg)
                h264dpk_pkg::PH_HDR: begin
                    if (ntype >= h264dpk_pkg::NAL_SINGLE_MIN &&
                        ntype <= h264dpk_pkg::NAL_SINGLE_MAX) begin
                        if (room_five) begin
                            push_cmd.kind = h264dpk_pkg::CMD_START;
                            fc_next       = fc_reg + FC_FIVE;
                            phase_next    = h264dpk_pkg::PH_SGL;
                        end else begin
                            perr_next  = 1'b1;
                            phase_next = h264dpk_pkg::PH_FUB;
                        end
                    end else if (ntype == h264dpk_pkg::NAL_STAP_A) begin
                        phase_next = h264dpk_pkg::PH_LHI;
                    end else if (ntype == h264dpk_pkg::NAL_FU_A) begin
                        ind_next   = s_tdata[7:5];
                        phase_next = h264dpk_pkg::PH_FUH;
                    end else begin
                        perr_next  = 1'b1;
                        phase_next = h264dpk_pkg::PH_FUB;
                    end
                end
                h264dpk_pkg::PH_SGL: begin
                    if (room_one) begin
                        push_cmd.kind = h264dpk_pkg::CMD_BYTE;
                        fc_next       = fc_reg + 1'b1;
                    end else begin
                        perr_next  = 1'b1;
                        phase_next = h264dpk_pkg::PH_FUB;
                    end
                end
                h264dpk_pkg::PH_LHI: begin
                    lhi_next   = s_tdata;
                    phase_next = h264dpk_pkg::PH_LLO;
                end
                h264dpk_pkg::PH_LLO: begin
                    if (len == '0) begin
                        perr_next  = 1'b1;
                        phase_next = h264dpk_pkg::PH_FUB;
                    end else begin
                        left_next  = len;
                        phase_next = h264dpk_pkg::PH_SHD;
                    end
                end
                h264dpk_pkg::PH_SHD: begin
                    if (room_five) begin
                        push_cmd.kind = h264dpk_pkg::CMD_START;
                        fc_next       = fc_reg + FC_FIVE;
                        left_next     = left_reg - 1'b1;
                        phase_next    = (left_reg == 16'd1) ? h264dpk_pkg::PH_LHI
                                                            : h264dpk_pkg::PH_SBD;
                    end else begin
                        perr_next  = 1'b1;
                        phase_next = h264dpk_pkg::PH_FUB;
                    end
                end
                h264dpk_pkg::PH_SBD: begin
                    if (room_one) begin
                        push_cmd.kind = h264dpk_pkg::CMD_BYTE;
                        fc_next       = fc_reg + 1'b1;
                        left_next     = left_reg - 1'b1;
                        if (left_reg == 16'd1) begin
                            phase_next = h264dpk_pkg::PH_LHI;
                        end
                    end else begin
                        perr_next  = 1'b1;
                        phase_next = h264dpk_pkg::PH_FUB;
                    end
                end
                h264dpk_pkg::PH_FUH: begin
                    phase_next = h264dpk_pkg::PH_FUB;
                    if (fu_s && !fu_e) begin
                        if (frag_open_reg) begin
                            // repeated start, ignore its payload
                            discard_next = 1'b1;
                        end else begin
                            frag_open_next = 1'b1;
                            if (room_five) begin
                                push_cmd.kind = h264dpk_pkg::CMD_START;
                                push_cmd.data = {ind_reg, s_tdata[4:0]};
                                fc_next       = fc_reg + FC_FIVE;
                            end else begin
                                perr_next = 1'b1;
                            end
                        end
                    end else if (!fu_s && !fu_e) begin
                        if (!frag_open_reg) begin
                            perr_next = 1'b1;
                        end
                    end else if (!fu_s && fu_e) begin
                        if (frag_open_reg) begin
                            frag_open_next = 1'b0;
                        end else begin
                            perr_next = 1'b1;
                        end
                    end else begin
                        frag_open_next = 1'b0;
                        perr_next      = 1'b1;
                    end
                end
                h264dpk_pkg::PH_FUB: begin
                    if (!perr_reg && !discard_reg) begin
                        if (room_one) begin
                            push_cmd.kind = h264dpk_pkg::CMD_BYTE;
                            fc_next       = fc_reg + 1'b1;
                        end else begin
                            perr_next = 1'b1;
                        end
                    end
                end
                default: begin
                    phase_next = h264dpk_pkg::PH_HDR;
                end
            endcase
        end

        if (s_tlast) begin
            // packet ending inside a length, a stap nal header or body, or an fu header is short
            if (!perr_next && (phase_next == h264dpk_pkg::PH_LLO ||
                               phase_next == h264dpk_pkg::PH_SHD ||
                               phase_next == h264dpk_pkg::PH_SBD ||
                               phase_next == h264dpk_pkg::PH_FUH)) begin
                perr_next = 1'b1;
            end
            if (perr_next || (marker && fc_next == '0)) begin
                push_cmd.drop  = 1'b1;
                push_cmd.kreq  = good_reg;
                good_next      = 1'b0;
                fc_next        = '0;
                frag_open_next = 1'b0;
            end else if (marker) begin
                fc_ext         = {{FL_W{1'b0}}, fc_next};
                push_cmd.done  = 1'b1;
                push_cmd.flen  = fc_ext[FL_W-1:0];
                good_next      = 1'b1;
                fc_next        = '0;
                frag_open_next = 1'b0;
            end
            phase_next   = h264dpk_pkg::PH_HDR;
            discard_next = 1'b0;
            perr_next    = 1'b0;
            left_next    = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= h264dpk_pkg::PH_HDR;
            left_reg      <= '0;
            frag_open_reg <= 1'b0;
            discard_reg   <= 1'b0;
            perr_reg      <= 1'b0;
            fc_reg        <= '0;
            good_reg      <= 1'b0;
        end else if (push) begin
            phase_reg     <= phase_next;
            left_reg      <= left_next;
            frag_open_reg <= frag_open_next;
            discard_reg   <= discard_next;
            perr_reg      <= perr_next;
            fc_reg        <= fc_next;
            good_reg      <= good_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ind_reg <= ind_next;
            lhi_reg <= lhi_next;
        end
    end

endmodule

// ----- hdl/h264dpk_queue.sv -----
// short command queue between the parser and the beat emitter
// depends on h264dpk_pkg

module h264dpk_queue #(
    parameter int unsigned DEPTH = h264dpk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    push,
    input  h264dpk_pkg::cmd_t       push_cmd,
    input  logic                    pop,
    output h264dpk_pkg::cmd_t       head,
    output h264dpk_pkg::q_status_t  status
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    h264dpk_pkg::cmd_t  mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push;
    logic               do_pop;

    assign status.full  = count_reg == CNT_FULL;
    assign status.empty = count_reg == '0;
    assign head         = mem_reg[rd_ptr_reg];
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- hdl/h264dpk_back.sv -----
// beat emitter: expands queued commands into output beats behind an output register
// depends on h264dpk_pkg

module h264dpk_back (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  h264dpk_pkg::cmd_t                     head,
    input  h264dpk_pkg::q_status_t                q_status,
    output logic                                  pop,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [h264dpk_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                  m_tuser,
    output logic                                  m_tlast
);

    localparam int unsigned FL_W  = h264dpk_pkg::FRAME_LEN_W;
    localparam int unsigned PAD_W = h264dpk_pkg::OUT_TDATA_W - h264dpk_pkg::BYTE_W - FL_W - 3;

    logic [2:0]                       idx_reg, idx_next;
    logic                             valid_reg, valid_next;
    logic [h264dpk_pkg::BYTE_W-1:0]   byte_reg, byte_next;
    logic                             oval_reg, oval_next;
    logic                             done_reg, done_next;
    logic [FL_W-1:0]                  flen_reg, flen_next;
    logic                             drop_reg, drop_next;
    logic                             kreq_reg, kreq_next;
    logic                             last_reg, last_next;

    logic load;
    logic last_beat;

    assign load      = !q_status.empty && (!valid_reg || m_tready);
    assign last_beat = head.kind != h264dpk_pkg::CMD_START ||
                       idx_reg == h264dpk_pkg::START_LAST_IDX;
    assign pop       = load && last_beat;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
            idx_next   = last_beat ? '0 : idx_reg + 1'b1;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_comb begin
        byte_next = '0;
        oval_next = 1'b1;
        unique case (head.kind)
            h264dpk_pkg::CMD_NONE: begin
                oval_next = 1'b0;
            end
            h264dpk_pkg::CMD_BYTE: begin
                byte_next = head.data;
            end
            h264dpk_pkg::CMD_START: begin
                if (idx_reg == h264dpk_pkg::START_ONE_IDX) begin
                    byte_next = h264dpk_pkg::START_ONE_BYTE;
                end else if (idx_reg == h264dpk_pkg::START_LAST_IDX) begin
                    byte_next = head.data;
                end
            end
            default: begin
                oval_next = 1'b0;
            end
        endcase
        // frame status rides on the final beat only
        last_next = last_beat;
        done_next = last_beat && head.done;
        flen_next = last_beat ? head.flen : '0;
        drop_next = last_beat && head.drop;
        kreq_next = last_beat && head.kreq;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            byte_reg <= byte_next;
            oval_reg <= oval_next;
            done_reg <= done_next;
            flen_reg <= flen_next;
            drop_reg <= drop_next;
            kreq_reg <= kreq_next;
            last_reg <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_W{1'b0}}, kreq_reg, drop_reg, flen_reg, done_reg, byte_reg};
    assign m_tuser  = oval_reg;
    assign m_tlast  = last_reg;

    // a start code in flight keeps its command at the head of the queue
    a_start_held: assert property (@(posedge aclk) disable iff (!aresetn)
        idx_reg != '0 |-> !q_status.empty && head.kind == h264dpk_pkg::CMD_START)
        else $error("start sequence lost its command");

    // frame status only on the last beat of a byte
    a_status_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !last_reg |-> !done_reg && !drop_reg && !kreq_reg && flen_reg == '0)
        else $error("frame status on a non-final beat");

    // a frame is never both completed and dropped
    a_done_xor_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> !(done_reg && drop_reg))
        else $error("frame done and drop together");

    // a beat without stream data carries a zero byte
    a_idle_byte_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !oval_reg |-> byte_reg == '0)
        else $error("nonzero byte on a beat without data");

endmodule

// ----- hdl/h264_rtp_depacketizer_unit.sv -----
// H.264 RTP depacketizer (single NAL, STAP-A, FU-A) turning payload bytes into an Annex B stream.
// The parser accepts one payload byte per cycle while the queue is not full and classifies it;
// each byte becomes one queued command. The emitter expands a command into one beat, or into
// five beats (00 00 00 01 and the NAL header) where a NAL unit starts. The output port moves one
// beat per cycle while m_tready is high, so each NAL unit started pulls the sustained input rate
// below one byte per cycle; a queue of QUEUE_DEPTH commands absorbs those bursts. An accepted
// byte passes through the queue and the output register before its first beat. Frame status
// (done with its length, or drop with a keyframe request) rides on the last beat of the byte
// that ends a packet; m_tlast marks each byte's last beat. No memory needs clearing after reset.
// depends on h264dpk_pkg, h264dpk_front, h264dpk_queue, h264dpk_back

module h264_rtp_depacketizer_unit #(
    parameter int unsigned MAX_FRAME_BYTES = h264dpk_pkg::MAX_FRAME_BYTES_DEF,
    parameter int unsigned QUEUE_DEPTH     = h264dpk_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [h264dpk_pkg::BYTE_W-1:0]        s_tdata,    // payload_byte
    input  logic [h264dpk_pkg::IN_USER_W-1:0]     s_tuser,    // packet_first, marker_bit
    input  logic                                  s_tlast,    // packet_last
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // out_byte, frame_done, frame_length, frame_drop, keyframe_request, zero pad
    output logic [h264dpk_pkg::OUT_TDATA_W-1:0]   m_tdata,
    output logic                                  m_tuser,    // out_valid
    output logic                                  m_tlast     // run_last
);

    h264dpk_pkg::cmd_t       push_cmd;
    h264dpk_pkg::cmd_t       head;
    h264dpk_pkg::q_status_t  q_status;
    logic                    push;
    logic                    pop;

    h264dpk_front #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .q_status (q_status),
        .push     (push),
        .push_cmd (push_cmd)
    );

    h264dpk_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    h264dpk_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .q_status (q_status),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- sim/tb_h264_rtp_depacketizer_unit.sv -----
`timescale 1ns / 1ps
// self-checking bench for h264_rtp_depacketizer_unit: random rtp payload packets in,
// annex b beats checked against an in-bench model of the depacketizer
// depends on h264dpk_pkg and the rtl of h264_rtp_depacketizer_unit

module tb_h264_rtp_depacketizer_unit;
    import h264dpk_pkg::*;

    // small frame cap so the overflow path is reachable in a short run
    localparam int unsigned FRAME_CAP  = 1024;
    localparam int unsigned RAND_ITEMS = 450;
    localparam logic [4:0]  NAL_UNSPEC = 5'd0;

    localparam int unsigned DONE_BIT = BYTE_W;
    localparam int unsigned FLEN_LSB = BYTE_W + 1;
    localparam int unsigned DROP_BIT = FLEN_LSB + FRAME_LEN_W;
    localparam int unsigned KREQ_BIT = DROP_BIT + 1;

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              first;
        logic              last;
        logic              marker;
    } pay_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0]      data;
        logic                   valid;
        logic                   done;
        logic [FRAME_LEN_W-1:0] flen;
        logic                   drop;
        logic                   kreq;
        logic                   last;
    } beat_t;

    typedef enum {STY_SINGLE, STY_STAP, STY_FU} pkt_style_t;

    typedef enum {
        BRK_TYPE, BRK_ZERO_LEN, BRK_SHORT_LEN, BRK_OVERRUN, BRK_SHORT_FU, BRK_ORPHAN,
        BRK_START_END, BRK_NO_END, BRK_NO_START, BRK_EMPTY_MARK, BRK_NOISE
    } brk_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [BYTE_W-1:0]    s_tdata  = '0;
    logic [IN_USER_W-1:0] s_tuser  = '0;
    logic                 s_tlast  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 m_tlast;

    h264_rtp_depacketizer_unit #(.MAX_FRAME_BYTES(FRAME_CAP)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    pay_item_t         pending[$];
    logic [BYTE_W-1:0] pkt[$];
    beat_t             stream_expect[$];

    // depacketizer model state
    phase_t            phase       = PH_HDR;
    logic [7:0]        indicator   = '0;
    logic [7:0]        len_hi      = '0;
    logic [15:0]       unit_left   = '0;
    logic              frag_open   = 1'b0;
    logic              skip_body   = 1'b0;
    logic              pkt_err     = 1'b0;
    int unsigned       frame_bytes = 0;
    logic              good_frame  = 1'b0;
    logic [BYTE_W-1:0] beat_buf[5];
    int unsigned       n_beats;

    int unsigned err_count      = 0;
    int unsigned beats_seen     = 0;
    int unsigned bytes_taken    = 0;
    int unsigned frames_done    = 0;
    int unsigned frames_dropped = 0;
    int unsigned s_calm = 0, m_calm = 0, hold_off = 0, stall_left = 0;
    pay_item_t   cur_item;
    beat_t       want_beat, seen_beat;

    function automatic void flag_error();
        pkt_err = 1'b1;
        phase   = PH_FUB;
    endfunction

    function automatic bit has_room(input int unsigned n);
        if (frame_bytes + n > FRAME_CAP) begin
            flag_error();
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic void push_data(input logic [7:0] b);
        if (!has_room(1) || n_beats >= 5) return;
        beat_buf[n_beats] = b;
        n_beats++;
        frame_bytes++;
    endfunction

    function automatic bit push_start(input logic [7:0] hdr);
        if (!has_room(5)) return 1'b0;
        beat_buf[0] = 8'h00;
        beat_buf[1] = 8'h00;
        beat_buf[2] = 8'h00;
        beat_buf[3] = START_ONE_BYTE;
        beat_buf[4] = hdr;
        n_beats = 5;
        frame_bytes += 5;
        return 1'b1;
    endfunction

    // expected beats for one accepted payload byte
    function automatic void depack_predict(input pay_item_t it);
        logic [7:0]             b;
        logic [4:0]             t;
        logic [15:0]            ulen;
        logic                   fs, fe, done_f, drop_f, kreq_f;
        logic [FRAME_LEN_W-1:0] len_f;
        int unsigned            n_out;
        beat_t                  bt;
        b = it.data;
        n_beats = 0;
        done_f = 1'b0;
        drop_f = 1'b0;
        kreq_f = 1'b0;
        len_f = '0;
        if (it.first && phase != PH_HDR) begin
            flag_error();
        end else begin
            case (phase)
                PH_HDR: begin
                    t = b[4:0];
                    if (t >= NAL_SINGLE_MIN && t <= NAL_SINGLE_MAX) begin
                        phase = PH_SGL;
                        void'(push_start(b));
                    end else if (t == NAL_STAP_A) begin
                        phase = PH_LHI;
                    end else if (t == NAL_FU_A) begin
                        indicator = b;
                        phase = PH_FUH;
                    end else begin
                        flag_error();
                    end
                end
                PH_SGL: push_data(b);
                PH_LHI: begin
                    len_hi = b;
                    phase = PH_LLO;
                end
                PH_LLO: begin
                    ulen = {len_hi, b};
                    if (ulen == 0) begin
                        flag_error();
                    end else begin
                        unit_left = ulen;
                        phase = PH_SHD;
                    end
                end
                PH_SHD: begin
                    if (push_start(b)) begin
                        unit_left = unit_left - 1'b1;
                        phase = (unit_left != 0) ? PH_SBD : PH_LHI;
                    end
                end
                PH_SBD: begin
                    push_data(b);
                    if (!pkt_err) begin
                        unit_left = unit_left - 1'b1;
                        if (unit_left == 0) phase = PH_LHI;
                    end
                end
                PH_FUH: begin
                    fs = b[FU_START_BIT];
                    fe = b[FU_END_BIT];
                    phase = PH_FUB;
                    if (fs && !fe) begin
                        // a second start while a fragment is open is swallowed
                        if (frag_open) begin
                            skip_body = 1'b1;
                        end else begin
                            frag_open = 1'b1;
                            void'(push_start({indicator[7:5], b[4:0]}));
                        end
                    end else if (!fs && !fe) begin
                        if (!frag_open) flag_error();
                    end else if (!fs && fe) begin
                        if (frag_open) frag_open = 1'b0;
                        else flag_error();
                    end else begin
                        frag_open = 1'b0;
                        flag_error();
                    end
                end
                default: begin
                    if (!pkt_err && !skip_body) push_data(b);
                end
            endcase
        end
        if (it.last) begin
            if (!pkt_err && phase >= PH_LLO && phase <= PH_FUH) flag_error();
            if (pkt_err || (it.marker && frame_bytes == 0)) begin
                drop_f = 1'b1;
                kreq_f = good_frame;
                good_frame = 1'b0;
                frame_bytes = 0;
                frag_open = 1'b0;
                frames_dropped++;
            end else if (it.marker) begin
                done_f = 1'b1;
                len_f = frame_bytes[FRAME_LEN_W-1:0];
                good_frame = 1'b1;
                frame_bytes = 0;
                frag_open = 1'b0;
                frames_done++;
            end
            phase = PH_HDR;
            skip_body = 1'b0;
            pkt_err = 1'b0;
            unit_left = '0;
        end
        n_out = (n_beats > 0) ? n_beats : 1;
        for (int k = 0; k < n_out; k++) begin
            bt.data  = (n_beats > 0) ? beat_buf[k] : 8'h00;
            bt.valid = (n_beats > 0);
            bt.last  = (k == n_out - 1);
            bt.done  = bt.last && done_f;
            bt.flen  = bt.last ? len_f : '0;
            bt.drop  = bt.last && drop_f;
            bt.kreq  = bt.last && kreq_f;
            stream_expect.push_back(bt);
        end
    endfunction

    // mostly back to back, sometimes short gaps, rarely long ones
    function automatic int unsigned pick_idle(inout int unsigned calm);
        int unsigned r;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm = $urandom_range(20, 80);
            return 0;
        end
        if (r < 65) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                depack_predict(cur_item);
                bytes_taken++;
            end
            if (hold_off > 0) begin
                hold_off--;
                s_tvalid <= 1'b0;
            end else if (pending.size() > 0) begin
                cur_item = pending.pop_front();
                s_tdata  <= cur_item.data;
                s_tuser  <= {cur_item.marker, cur_item.first};
                s_tlast  <= cur_item.last;
                s_tvalid <= 1'b1;
                hold_off = pick_idle(s_calm);
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (stall_left == 0) stall_left = pick_idle(m_calm);
            else stall_left--;
            m_tready <= (stall_left == 0);
        end
    end

    task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $display("%0t ns: beat %0d %s expected 0x%0h got 0x%0h",
                     $time, beats_seen, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            beats_seen++;
            seen_beat.data  = m_tdata[BYTE_W-1:0];
            seen_beat.valid = m_tuser;
            seen_beat.done  = m_tdata[DONE_BIT];
            seen_beat.flen  = m_tdata[FLEN_LSB +: FRAME_LEN_W];
            seen_beat.drop  = m_tdata[DROP_BIT];
            seen_beat.kreq  = m_tdata[KREQ_BIT];
            seen_beat.last  = m_tlast;
            if (stream_expect.size() == 0) begin
                err_count++;
                $display("%0t ns: beat %0d unexpected, expected nothing got 0x%0h",
                         $time, beats_seen, seen_beat);
            end else begin
                want_beat = stream_expect.pop_front();
                check_field("out_byte", want_beat.data, seen_beat.data);
                check_field("out_valid", want_beat.valid, seen_beat.valid);
                check_field("frame_done", want_beat.done, seen_beat.done);
                check_field("frame_length", want_beat.flen, seen_beat.flen);
                check_field("frame_drop", want_beat.drop, seen_beat.drop);
                check_field("keyframe_request", want_beat.kreq, seen_beat.kreq);
                check_field("run_last", want_beat.last, seen_beat.last);
            end
        end
    end

    // ---------------- stimulus ----------------

    function automatic logic [7:0] nal_hdr(input logic [4:0] t);
        logic [7:0] h;
        h = 8'($urandom);
        h[4:0] = t;
        return h;
    endfunction

    function automatic logic [7:0] fu_hdr(input logic s, input logic e, input logic [4:0] t);
        logic [7:0] h;
        h = {3'($urandom), t};
        h[FU_START_BIT] = s;
        h[FU_END_BIT] = e;
        return h;
    endfunction

    function automatic int unsigned pick_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(0, 6);
        return $urandom_range(7, 40);
    endfunction

    task automatic add_body(input int unsigned n);
        repeat (n) pkt.push_back(8'($urandom));
    endtask

    // turn the packet under construction into payload beats
    task automatic send_pkt(input logic mark, input logic cut_first, input logic cut_last);
        pay_item_t it;
        foreach (pkt[i]) begin
            it.data   = pkt[i];
            it.first  = (i == 0) && !cut_first;
            it.last   = (i == pkt.size() - 1) && !cut_last;
            it.marker = mark;
            pending.push_back(it);
        end
        pkt.delete();
    endtask

    task automatic build_single(input logic mark);
        pkt.push_back(nal_hdr(5'($urandom_range(NAL_SINGLE_MIN, NAL_SINGLE_MAX))));
        add_body(pick_len());
        send_pkt(mark, 1'b0, 1'b0);
    endtask

    task automatic build_stap(input logic mark);
        int unsigned ulen;
        pkt.push_back(nal_hdr(NAL_STAP_A));
        repeat ($urandom_range(1, 3)) begin
            ulen = 1 + pick_len();
            pkt.push_back(8'(ulen >> 8));
            pkt.push_back(8'(ulen));
            pkt.push_back(8'($urandom));
            add_body(ulen - 1);
        end
        send_pkt(mark, 1'b0, 1'b0);
    endtask

    task automatic build_fu(input logic mark);
        logic [7:0] ind;
        logic [4:0] t;
        ind = nal_hdr(NAL_FU_A);
        t = 5'($urandom);
        pkt.push_back(ind);
        pkt.push_back(fu_hdr(1'b1, 1'b0, t));
        add_body(pick_len());
        send_pkt(1'b0, 1'b0, 1'b0);
        if ($urandom_range(0, 9) == 0) begin
            pkt.push_back(ind);
            pkt.push_back(fu_hdr(1'b1, 1'b0, t));
            add_body(pick_len());
            send_pkt(1'b0, 1'b0, 1'b0);
        end
        repeat ($urandom_range(0, 2)) begin
            pkt.push_back(ind);
            pkt.push_back(fu_hdr(1'b0, 1'b0, t));
            add_body(pick_len());
            send_pkt(1'b0, 1'b0, 1'b0);
        end
        pkt.push_back(ind);
        pkt.push_back(fu_hdr(1'b0, 1'b1, t));
        add_body(pick_len());
        send_pkt(mark, 1'b0, 1'b0);
    endtask

    task automatic build_frame();
        int unsigned groups;
        pkt_style_t  sty;
        logic        mark;
        groups = $urandom_range(1, 4);
        for (int g = 0; g < groups; g++) begin
            mark = (g == groups - 1);
            sty = pkt_style_t'($urandom_range(STY_SINGLE, STY_FU));
            case (sty)
                STY_SINGLE: build_single(mark);
                STY_STAP:   build_stap(mark);
                default:    build_fu(mark);
            endcase
        end
    endtask

    task automatic build_broken();
        brk_t        kind;
        logic        mark;
        logic [4:0]  t;
        logic [7:0]  hi, lo;
        int unsigned ulen;
        pay_item_t   it;
        kind = brk_t'($urandom_range(BRK_TYPE, BRK_NOISE));
        mark = 1'($urandom_range(0, 1));
        t = 5'($urandom);
        case (kind)
            BRK_TYPE: begin
                while ((t >= NAL_SINGLE_MIN && t <= NAL_SINGLE_MAX) ||
                       t == NAL_STAP_A || t == NAL_FU_A)
                    t = 5'($urandom);
                pkt.push_back(nal_hdr(t));
                add_body(pick_len());
            end
            BRK_ZERO_LEN: begin
                pkt.push_back(nal_hdr(NAL_STAP_A));
                pkt.push_back(8'h00);
                pkt.push_back(8'h00);
                add_body($urandom_range(0, 3));
            end
            BRK_SHORT_LEN: begin
                pkt.push_back(nal_hdr(NAL_STAP_A));
                if ($urandom_range(0, 1)) begin
                    pkt.push_back(8'h00);
                    pkt.push_back(8'h01);
                    pkt.push_back(8'($urandom));
                end
                pkt.push_back(8'($urandom));
                if ($urandom_range(0, 1)) pkt.push_back(8'($urandom));
            end
            BRK_OVERRUN: begin
                // unit length runs past the end of the packet
                hi = 8'($urandom);
                lo = 8'($urandom);
                if (hi == 0 && lo < 2) lo = 8'd2;
                ulen = {hi, lo};
                pkt.push_back(nal_hdr(NAL_STAP_A));
                pkt.push_back(hi);
                pkt.push_back(lo);
                pkt.push_back(8'($urandom));
                add_body($urandom_range(0, (ulen - 2 < 8) ? ulen - 2 : 8));
            end
            BRK_SHORT_FU: pkt.push_back(nal_hdr(NAL_FU_A));
            BRK_ORPHAN: begin
                pkt.push_back(nal_hdr(NAL_FU_A));
                pkt.push_back(fu_hdr(1'b0, 1'($urandom), t));
                add_body(pick_len());
            end
            BRK_START_END: begin
                pkt.push_back(nal_hdr(NAL_FU_A));
                pkt.push_back(fu_hdr(1'b1, 1'b1, t));
                add_body(pick_len());
            end
            BRK_NO_END, BRK_NO_START: begin
                pkt.push_back(nal_hdr(5'($urandom_range(NAL_SINGLE_MIN, NAL_SINGLE_MAX))));
                add_body($urandom_range(1, 6));
            end
            BRK_EMPTY_MARK: begin
                pkt.push_back(nal_hdr(NAL_STAP_A));
                mark = 1'b1;
            end
            default: begin
                repeat ($urandom_range(1, 6)) begin
                    it = pay_item_t'($urandom);
                    pending.push_back(it);
                end
            end
        endcase
        if (pkt.size() > 0) send_pkt(mark, kind == BRK_NO_START, kind == BRK_NO_END);
    endtask

    initial begin
        int unsigned direct_n;
        int unsigned total_items;
        bit          cap_tried;
        cap_tried = 1'b0;

        // single nal with extreme body bytes, completes a frame
        pkt.push_back({3'b011, NAL_SINGLE_MIN});
        pkt.push_back(8'h00);
        pkt.push_back(8'hff);
        send_pkt(1'b1, 1'b0, 1'b0);
        // unsupported type with forbidden bit set, drop with keyframe request
        pkt.push_back({3'b111, NAL_UNSPEC});
        send_pkt(1'b1, 1'b0, 1'b0);
        // stap-a: one-byte unit, then a zero length
        pkt.push_back({3'b011, NAL_STAP_A});
        pkt.push_back(8'h00);
        pkt.push_back(8'h01);
        pkt.push_back({3'b011, NAL_SINGLE_MAX});
        pkt.push_back(8'h00);
        pkt.push_back(8'h00);
        send_pkt(1'b0, 1'b0, 1'b0);
        // stap-a ending inside the length field
        pkt.push_back({3'b000, NAL_STAP_A});
        pkt.push_back(8'h00);
        send_pkt(1'b0, 1'b0, 1'b0);
        // fu-a start, repeated start, end
        pkt.push_back({3'b011, NAL_FU_A});
        pkt.push_back(fu_hdr(1'b1, 1'b0, 5'd5));
        pkt.push_back(8'h11);
        send_pkt(1'b0, 1'b0, 1'b0);
        pkt.push_back({3'b011, NAL_FU_A});
        pkt.push_back(fu_hdr(1'b1, 1'b0, 5'd5));
        pkt.push_back(8'h22);
        send_pkt(1'b0, 1'b0, 1'b0);
        pkt.push_back({3'b011, NAL_FU_A});
        pkt.push_back(fu_hdr(1'b0, 1'b1, 5'd5));
        pkt.push_back(8'h33);
        send_pkt(1'b1, 1'b0, 1'b0);
        // orphan middle fragment, then start plus end
        pkt.push_back({3'b010, NAL_FU_A});
        pkt.push_back(fu_hdr(1'b0, 1'b0, 5'd5));
        send_pkt(1'b0, 1'b0, 1'b0);
        pkt.push_back({3'b010, NAL_FU_A});
        pkt.push_back(fu_hdr(1'b1, 1'b1, 5'd5));
        send_pkt(1'b1, 1'b0, 1'b0);
        direct_n = pending.size();

        while (pending.size() < direct_n + RAND_ITEMS) begin
            if (!cap_tried && pending.size() > direct_n + RAND_ITEMS / 3) begin
                cap_tried = 1'b1;
                // close whatever is open, then fill a frame to just under or just past the cap
                pkt.push_back(nal_hdr(NAL_STAP_A));
                send_pkt(1'b1, 1'b0, 1'b0);
                repeat ($urandom_range(201, 204)) begin
                    pkt.push_back(nal_hdr(NAL_SINGLE_MIN));
                    send_pkt(1'b0, 1'b0, 1'b0);
                end
                pkt.push_back(nal_hdr(NAL_SINGLE_MAX));
                add_body(12);
                send_pkt(1'b1, 1'b0, 1'b0);
            end else if ($urandom_range(0, 99) < 70) begin
                build_frame();
            end else begin
                build_broken();
            end
        end
        total_items = pending.size();

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending.size() != 0 || s_tvalid) @(posedge aclk);
        while (stream_expect.size() != 0) @(posedge aclk);
        repeat (16) @(posedge aclk);

        $display("run covered %0d payload bytes (%0d directed) giving %0d stream beats",
                 total_items, direct_n, beats_seen);
        $display("%0d frames completed, %0d frames dropped, %0d mismatches",
                 frames_done, frames_dropped, err_count);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial begin
        #4_000_000;
        $display("timeout with %0d payload bytes taken, %0d beats outstanding",
                 bytes_taken, stream_expect.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
